>>> hw/rtl/iirdf1_pkg.sv
// shared widths, register codes and configuration bundle for the direct form one iir filter
`default_nettype none

package iirdf1_pkg;

  // sample and coefficient formats
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 32;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int FRAC_SHIFT = 28;

  // order register and coefficient counts held in registers
  localparam int ORDER_W = 3;
  localparam int NUM_B   = 5;
  localparam int NUM_A   = 4;

  // default history depth
  localparam int MAX_TAPS_ORDER_DEF = 4;

  // apb port
  localparam int CFG_ADDR_W = 6;
  localparam int CFG_DATA_W = 64;
  localparam int REG_IDX_W  = 3;
  localparam int REG_LSB    = 3;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_FILTER_ORDER = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_COEF_B0_B1   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COEF_B2_B3   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_COEF_B4_A1   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_COEF_A2_A3   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_COEF_A4      = 3'd5;

  // configuration as seen by the datapath; a[j] holds coefficient a(j+1)
  typedef struct packed {
    logic [ORDER_W-1:0]            order;
    logic [NUM_B-1:0][COEF_W-1:0]  b;
    logic [NUM_A-1:0][COEF_W-1:0]  a;
    logic                          hist_clr;
  } cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/iir_filter_direct_form_one_top.sv
// direct form one iir filter, order 0 to 4, with apb coefficient registers
//
//   port group  dir  content                               request taken when
//   s_*         in   tdata[15:0] = sample                  s_tvalid && s_tready
//   m_*         out  tdata[15:0] = filtered, tuser = sat   m_tvalid && m_tready
//   apb         in   registers at byte address 8*index     psel && penable && pwrite
//
// one sample per clock unless the output stalls; via input stage then output register
// the loop that sets the rate is a1 times y(n-1), the tap sum, rounding and clipping
// the other taps are multiplied for the next sample in the cells and registered
// reset clears histories, tap terms and both pipeline stages
// with the output stalled one sample waits in the input stage and one in the output register
`default_nettype none

module iir_filter_direct_form_one_top #(
  parameter int MAX_TAPS_ORDER = iirdf1_pkg::MAX_TAPS_ORDER_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // sample stream
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [iirdf1_pkg::SAMPLE_W-1:0]     s_tdata,   // [15:0] sample
  // result stream
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic      [iirdf1_pkg::SAMPLE_W-1:0]     m_tdata,   // [15:0] filtered
  output logic      [0:0]                          m_tuser,   // [0] saturated
  // configuration
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [iirdf1_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [iirdf1_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic      [iirdf1_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                     pready
);

  localparam int SW    = iirdf1_pkg::SAMPLE_W;
  localparam int CW    = iirdf1_pkg::COEF_W;
  localparam int PW    = iirdf1_pkg::PROD_W;
  localparam int ACC_W = PW + $clog2(2 * MAX_TAPS_ORDER + 2);
  localparam int Q_W   = ACC_W - iirdf1_pkg::FRAC_SHIFT;

  iirdf1_pkg::cfg_t cfg;

  logic                   in_acc;
  logic                   advance;
  logic                   a_valid;
  logic signed [SW-1:0]   a_x;
  logic signed [PW-1:0]   a_prod;
  logic signed [PW-1:0]   b0_prod;

  logic signed [CW-1:0]   cb      [MAX_TAPS_ORDER];
  logic signed [CW-1:0]   ca      [MAX_TAPS_ORDER];
  logic                   tap_on  [MAX_TAPS_ORDER];
  logic signed [SW-1:0]   x_left  [MAX_TAPS_ORDER];
  logic signed [SW-1:0]   y_left  [MAX_TAPS_ORDER];
  logic signed [SW-1:0]   x_hist  [MAX_TAPS_ORDER];
  logic signed [SW-1:0]   y_hist  [MAX_TAPS_ORDER];
  logic signed [PW:0]     term    [MAX_TAPS_ORDER];

  logic signed [CW-1:0]    a1_eff;
  logic signed [PW-1:0]    a1_prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] rnd;
  logic signed [Q_W-1:0]   q;
  logic                    sat_hi;
  logic                    sat_lo;
  logic signed [SW-1:0]    y_new;

  // configuration registers
  iirdf1_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // handshake: the input stage moves on whenever the output register is free or drains
  assign advance  = a_valid && (!m_tvalid || m_tready);
  assign s_tready = !a_valid || advance;
  assign in_acc   = s_tvalid && s_tready;

  // input stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_acc) begin
      a_valid <= 1'b1;
    end else if (advance) begin
      a_valid <= 1'b0;
    end
  end

  // input stage payload with the b0 product
  assign b0_prod = signed'(cfg.b[0]) * signed'(s_tdata);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_x    <= signed'(s_tdata);
      a_prod <= b0_prod;
    end
  end

  // row of history cells, cell i holds delay i+1
  for (genvar i = 0; i < MAX_TAPS_ORDER; i++) begin : g_cell
    localparam int TAP = i + 1;

    assign tap_on[i] = (32'(cfg.order) >= 32'(TAP));

    if (TAP < iirdf1_pkg::NUM_B) begin : g_b
      assign cb[i] = tap_on[i] ? signed'(cfg.b[TAP]) : '0;
    end else begin : g_b_none
      assign cb[i] = '0;
    end

    // a1 is applied in the output loop, so the first cell carries no feedback weight
    if (i > 0 && TAP <= iirdf1_pkg::NUM_A) begin : g_a
      assign ca[i] = tap_on[i] ? signed'(cfg.a[TAP-1]) : '0;
    end else begin : g_a_none
      assign ca[i] = '0;
    end

    if (i == 0) begin : g_head
      assign x_left[i] = a_x;
      assign y_left[i] = y_new;
    end else begin : g_link
      assign x_left[i] = x_hist[i-1];
      assign y_left[i] = y_hist[i-1];
    end

    iirdf1_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .clr    (cfg.hist_clr),
      .shift  (advance),
      .coef_b (cb[i]),
      .coef_a (ca[i]),
      .x_in   (x_left[i]),
      .y_in   (y_left[i]),
      .x_hist (x_hist[i]),
      .y_hist (y_hist[i]),
      .term   (term[i])
    );
  end

  // feedback through a1 closes here
  assign a1_eff  = tap_on[0] ? signed'(cfg.a[0]) : '0;
  assign a1_prod = a1_eff * y_hist[0];

  // full-precision sum of all taps
  always_comb begin
    acc = ACC_W'(a_prod) - ACC_W'(a1_prod);
    for (int i = 0; i < MAX_TAPS_ORDER; i++) begin
      acc = acc + ACC_W'(term[i]);
    end
  end

  // round to nearest with ties up, then clip to q1.15
  assign rnd    = acc + (ACC_W'(1) <<< (iirdf1_pkg::FRAC_SHIFT - 1));
  assign q      = rnd[ACC_W-1:iirdf1_pkg::FRAC_SHIFT];
  assign sat_hi = !q[Q_W-1] && (|q[Q_W-2:SW-1]);
  assign sat_lo = q[Q_W-1] && !(&q[Q_W-2:SW-1]);

  always_comb begin
    priority if (sat_hi) begin
      y_new = {1'b0, {(SW-1){1'b1}}};
    end else if (sat_lo) begin
      y_new = {1'b1, {(SW-1){1'b0}}};
    end else begin
      y_new = q[SW-1:0];
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata    <= y_new;
      m_tuser[0] <= sat_hi || sat_lo;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/iirdf1_regs.sv
// apb register file holding filter order and coefficients
`default_nettype none

module iirdf1_regs (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [iirdf1_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [iirdf1_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [iirdf1_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                    pready,
  output iirdf1_pkg::cfg_t                        cfg
);

  logic [iirdf1_pkg::ORDER_W-1:0]    filter_order;
  logic [iirdf1_pkg::CFG_DATA_W-1:0] coef_b0_b1;
  logic [iirdf1_pkg::CFG_DATA_W-1:0] coef_b2_b3;
  logic [iirdf1_pkg::CFG_DATA_W-1:0] coef_b4_a1;
  logic [iirdf1_pkg::CFG_DATA_W-1:0] coef_a2_a3;
  logic [iirdf1_pkg::COEF_W-1:0]     coef_a4;

  logic [iirdf1_pkg::REG_IDX_W-1:0] idx;
  logic                             wr;
  logic                             idx_known;

  assign pready = 1'b1;
  assign idx    = paddr[iirdf1_pkg::CFG_ADDR_W-1:iirdf1_pkg::REG_LSB];
  assign wr     = psel && penable && pwrite;

  // listed registers
  always_comb begin
    unique case (idx)
      iirdf1_pkg::REG_FILTER_ORDER,
      iirdf1_pkg::REG_COEF_B0_B1,
      iirdf1_pkg::REG_COEF_B2_B3,
      iirdf1_pkg::REG_COEF_B4_A1,
      iirdf1_pkg::REG_COEF_A2_A3,
      iirdf1_pkg::REG_COEF_A4:  idx_known = 1'b1;
      default:                  idx_known = 1'b0;
    endcase
  end

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_order <= '0;
      coef_b0_b1   <= '0;
      coef_b2_b3   <= '0;
      coef_b4_a1   <= '0;
      coef_a2_a3   <= '0;
      coef_a4      <= '0;
    end else if (wr) begin
      unique case (idx)
        iirdf1_pkg::REG_FILTER_ORDER: filter_order <= pwdata[iirdf1_pkg::ORDER_W-1:0];
        iirdf1_pkg::REG_COEF_B0_B1:   coef_b0_b1   <= pwdata;
        iirdf1_pkg::REG_COEF_B2_B3:   coef_b2_b3   <= pwdata;
        iirdf1_pkg::REG_COEF_B4_A1:   coef_b4_a1   <= pwdata;
        iirdf1_pkg::REG_COEF_A2_A3:   coef_a2_a3   <= pwdata;
        iirdf1_pkg::REG_COEF_A4:      coef_a4      <= pwdata[iirdf1_pkg::COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      iirdf1_pkg::REG_FILTER_ORDER: prdata = iirdf1_pkg::CFG_DATA_W'(filter_order);
      iirdf1_pkg::REG_COEF_B0_B1:   prdata = coef_b0_b1;
      iirdf1_pkg::REG_COEF_B2_B3:   prdata = coef_b2_b3;
      iirdf1_pkg::REG_COEF_B4_A1:   prdata = coef_b4_a1;
      iirdf1_pkg::REG_COEF_A2_A3:   prdata = coef_a2_a3;
      iirdf1_pkg::REG_COEF_A4:      prdata = iirdf1_pkg::CFG_DATA_W'(coef_a4);
      default:                      prdata = '0;
    endcase
  end

  // unpack coefficients, lower-named one in the low half
  assign cfg.order    = filter_order;
  assign cfg.b[0]     = coef_b0_b1[31:0];
  assign cfg.b[1]     = coef_b0_b1[63:32];
  assign cfg.b[2]     = coef_b2_b3[31:0];
  assign cfg.b[3]     = coef_b2_b3[63:32];
  assign cfg.b[4]     = coef_b4_a1[31:0];
  assign cfg.a[0]     = coef_b4_a1[63:32];
  assign cfg.a[1]     = coef_a2_a3[31:0];
  assign cfg.a[2]     = coef_a2_a3[63:32];
  assign cfg.a[3]     = coef_a4;
  // any write to a listed register wipes both histories at the same edge
  assign cfg.hist_clr = wr && idx_known;

endmodule

`default_nettype wire

>>> hw/rtl/iirdf1_cell.sv
// one history cell: holds x and y of one delay and registers its weighted tap term
`default_nettype none

module iirdf1_cell (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      clr,
  input  wire logic                                      shift,
  input  wire logic signed [iirdf1_pkg::COEF_W-1:0]      coef_b,
  input  wire logic signed [iirdf1_pkg::COEF_W-1:0]      coef_a,
  input  wire logic signed [iirdf1_pkg::SAMPLE_W-1:0]    x_in,
  input  wire logic signed [iirdf1_pkg::SAMPLE_W-1:0]    y_in,
  output logic      signed [iirdf1_pkg::SAMPLE_W-1:0]    x_hist,
  output logic      signed [iirdf1_pkg::SAMPLE_W-1:0]    y_hist,
  output logic      signed [iirdf1_pkg::PROD_W:0]        term
);

  logic signed [iirdf1_pkg::SAMPLE_W-1:0] x_sel;
  logic signed [iirdf1_pkg::SAMPLE_W-1:0] y_sel;
  logic signed [iirdf1_pkg::PROD_W-1:0]   prod_b;
  logic signed [iirdf1_pkg::PROD_W-1:0]   prod_a;
  logic signed [iirdf1_pkg::PROD_W:0]     term_next;

  // the term is for the next sample, so look at what this cell will hold then
  assign x_sel = shift ? x_in : x_hist;
  assign y_sel = shift ? y_in : y_hist;

  assign prod_b    = coef_b * x_sel;
  assign prod_a    = coef_a * y_sel;
  assign term_next = (iirdf1_pkg::PROD_W+1)'(prod_b) - (iirdf1_pkg::PROD_W+1)'(prod_a);

  // history moves one place per finished sample
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      x_hist <= '0;
      y_hist <= '0;
    end else if (shift) begin
      x_hist <= x_in;
      y_hist <= y_in;
    end
  end

  // tap term tracks the history one step ahead
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      term <= '0;
    end else begin
      term <= term_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/iirdf1_checker.sv
// port-level checks for the iir filter top, bound to every instance
`default_nettype none

module iirdf1_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             s_tvalid,
  input wire logic                             s_tready,
  input wire logic                             m_tvalid,
  input wire logic                             m_tready,
  input wire logic [iirdf1_pkg::SAMPLE_W-1:0]  m_tdata,
  input wire logic [0:0]                       m_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // the clip flag only comes with a full-scale value
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> (m_tdata == 16'h7fff) || (m_tdata == 16'h8000))
    else $error("saturated flag without full-scale output");

  // a draining output never holds off the input
  a_no_bubble: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while output is taken");

  // a fresh result is raised only after its sample request has passed the input stage and the output register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result without a matching sample");

endmodule

bind iir_filter_direct_form_one_top iirdf1_checker u_iirdf1_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
